// ----- hdl/smse_pkg.sv -----
package smse_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned VAL_W    = 32;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;
  localparam logic [1:0] OP_RANGE  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] key_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] match_count;
    logic [OUT_CNT_W-1:0] total_count;
    logic [OUT_CNT_W-1:0] distinct_count;
  } out_item_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic clear;
    logic vld;
  } scan_ctl_t;

  // Counts gathered by the compare unit over one pass.
  typedef struct packed {
    logic [CNT_W-1:0] lt_cnt;
    logic [CNT_W-1:0] eq_cnt;
    logic [CNT_W-1:0] rng_cnt;
  } scan_res_t;

  // Low bits of a count as reported on the result channel.
  function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_CNT_W-1:0] t;
    t = {{OUT_CNT_W{1'b0}}, v};
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage

// ----- hdl/sorted_multiset_engine.sv -----
// Sorted multiset engine: keeps up to CAPACITY signed 32-bit values in
// ascending order and serves insert, delete-one-copy, occurrence count and
// inclusive range count.
// Input channel in_valid/in_ready/in_item carries one operation per item;
// the result channel out_valid/out_ready/out_item returns exactly one result
// item per operation, in order, with status, match count, total count and
// distinct count after the operation.
// Each accepted insert below capacity, delete, count or valid range first
// passes the stored values once through one compare unit, one value per
// cycle from the single read port, and then takes a decision step.
// An insert then moves each value above the insert point up by one place
// and a delete moves each value above the removed one down, each moved
// value with a read, then a write over the same memory, and a commit step
// follows. The result register is loaded once it is free. Full inserts and
// inverted ranges skip the pass and go straight to loading their result.
// in_ready is high only while the block is idle, one item at a time; the
// next item can be taken from the cycle its predecessor's result turns valid.
// A waiting result sits in the output register; the block goes on to accept
// the next item, and holds its following result until the first is taken.
// Reset empties the store at once: no clearing pass is needed.
module sorted_multiset_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smse_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output smse_pkg::out_item_t out_item
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MV_RD  = 3'd3;
  localparam logic [2:0] S_MV_WR  = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  smse_pkg::in_item_t           item_r, item_nxt;
  logic signed [smse_pkg::VAL_W-1:0] hi_r, hi_nxt;
  logic [smse_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [smse_pkg::CNT_W-1:0]   distinct_r, distinct_nxt;
  logic [smse_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                         pend_r, pend_nxt;
  logic [smse_pkg::CNT_W-1:0]   mv_idx_r, mv_idx_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [smse_pkg::CNT_W-1:0]   match_r, match_nxt;
  logic                         out_valid_r, out_valid_nxt;
  smse_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                         rd_en, wr_en;
  logic [smse_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
  logic [smse_pkg::VAL_W-1:0]   rd_data, wr_data;
  smse_pkg::scan_ctl_t          scan_ctl;
  smse_pkg::scan_res_t          scan_res;
  logic [smse_pkg::CNT_W-1:0]   mv_prev, mv_next;
  logic                         is_insert;

  smse_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  smse_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rd_data (rd_data),
    .lo      (item_r.key),
    .hi      (hi_r),
    .res     (scan_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign mv_prev   = mv_idx_r - smse_pkg::CNT_ONE;
  assign mv_next   = mv_idx_r + smse_pkg::CNT_ONE;
  assign is_insert = (item_r.op == smse_pkg::OP_INSERT);

  // Sequencer: one pass through the store, then the moves, then the result.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    hi_nxt        = hi_r;
    fill_nxt      = fill_r;
    distinct_nxt  = distinct_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    mv_idx_nxt    = mv_idx_r;
    status_nxt    = status_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    scan_ctl.clear = 1'b0;
    scan_ctl.vld   = pend_r;

    // The receiver took the waiting result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_item;
          hi_nxt         = (in_item.op == smse_pkg::OP_RANGE) ? in_item.key_high
                                                              : in_item.key;
          status_nxt     = smse_pkg::ST_OK;
          match_nxt      = '0;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          scan_ctl.clear = 1'b1;
          if (in_item.op == smse_pkg::OP_INSERT && fill_r == smse_pkg::CNT_CAP) begin
            status_nxt = smse_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_item.op == smse_pkg::OP_RANGE &&
                       in_item.key > in_item.key_high) begin
            status_nxt = smse_pkg::ST_BAD_RANGE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read one stored value a cycle; its compare lands in the next cycle.
        if (idx_r < fill_r) begin
          rd_en    = 1'b1;
          rd_addr  = idx_r[smse_pkg::ADDR_W-1:0];
          idx_nxt  = idx_r + smse_pkg::CNT_ONE;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        case (item_r.op)
          smse_pkg::OP_INSERT: begin
            // The insert point is the number of smaller values.
            mv_idx_nxt = fill_r;
            state_nxt  = (fill_r == scan_res.lt_cnt) ? S_COMMIT : S_MV_RD;
          end
          smse_pkg::OP_DELETE: begin
            if (scan_res.eq_cnt == '0) begin
              status_nxt = smse_pkg::ST_NOT_FOUND;
              state_nxt  = S_RESP;
            end else begin
              mv_idx_nxt = scan_res.lt_cnt;
              state_nxt  = (scan_res.lt_cnt + smse_pkg::CNT_ONE >= fill_r) ? S_COMMIT
                                                                           : S_MV_RD;
            end
          end
          default: begin
            match_nxt = scan_res.rng_cnt;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_MV_RD: begin
        // Fetch the neighbor that moves into the current place.
        rd_en     = 1'b1;
        rd_addr   = is_insert ? mv_prev[smse_pkg::ADDR_W-1:0]
                              : mv_next[smse_pkg::ADDR_W-1:0];
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        wr_en   = 1'b1;
        wr_addr = mv_idx_r[smse_pkg::ADDR_W-1:0];
        wr_data = rd_data;
        if (is_insert) begin
          mv_idx_nxt = mv_prev;
          state_nxt  = (mv_prev == scan_res.lt_cnt) ? S_COMMIT : S_MV_RD;
        end else begin
          mv_idx_nxt = mv_next;
          state_nxt  = (mv_next + smse_pkg::CNT_ONE >= fill_r) ? S_COMMIT : S_MV_RD;
        end
      end
      S_COMMIT: begin
        if (is_insert) begin
          wr_en    = 1'b1;
          wr_addr  = mv_idx_r[smse_pkg::ADDR_W-1:0];
          wr_data  = item_r.key;
          fill_nxt = fill_r + smse_pkg::CNT_ONE;
          if (scan_res.eq_cnt == '0) begin
            distinct_nxt = distinct_r + smse_pkg::CNT_ONE;
          end
        end else begin
          fill_nxt = fill_r - smse_pkg::CNT_ONE;
          if (scan_res.eq_cnt == smse_pkg::CNT_ONE) begin
            distinct_nxt = distinct_r - smse_pkg::CNT_ONE;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.status         = status_r;
          out_item_nxt.match_count    = smse_pkg::to_out_cnt(match_r);
          out_item_nxt.total_count    = smse_pkg::to_out_cnt(fill_r);
          out_item_nxt.distinct_count = smse_pkg::to_out_cnt(distinct_r);
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      distinct_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      distinct_r  <= distinct_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    mv_idx_r   <= mv_idx_nxt;
    status_r   <= status_nxt;
    match_r    <= match_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- hdl/smse_store.sv -----
module smse_store (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [smse_pkg::ADDR_W-1:0]            rd_addr,
  output logic [smse_pkg::VAL_W-1:0]             rd_data,
  input  logic                                   wr_en,
  input  logic [smse_pkg::ADDR_W-1:0]            wr_addr,
  input  logic [smse_pkg::VAL_W-1:0]             wr_data
);

  logic [smse_pkg::VAL_W-1:0] mem [smse_pkg::CAPACITY];
  logic [smse_pkg::VAL_W-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/smse_scan.sv -----
module smse_scan (
  input  logic                                clk,
  input  smse_pkg::scan_ctl_t                 ctl,
  input  logic signed [smse_pkg::VAL_W-1:0]   rd_data,
  input  logic signed [smse_pkg::VAL_W-1:0]   lo,
  input  logic signed [smse_pkg::VAL_W-1:0]   hi,
  output smse_pkg::scan_res_t                 res
);

  logic [smse_pkg::CNT_W-1:0] lt_r, eq_r, rng_r;
  logic ge, le, eq;

  // Shared compare of one stored value against both bounds.
  always_comb begin
    ge = rd_data >= lo;
    le = rd_data <= hi;
    eq = rd_data == lo;
  end

  // Accumulate the counts over one pass through the store.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lt_r  <= '0;
      eq_r  <= '0;
      rng_r <= '0;
    end else if (ctl.vld) begin
      if (!ge) begin
        lt_r <= lt_r + smse_pkg::CNT_ONE;
      end
      if (eq) begin
        eq_r <= eq_r + smse_pkg::CNT_ONE;
      end
      if (ge && le) begin
        rng_r <= rng_r + smse_pkg::CNT_ONE;
      end
    end
  end

  assign res.lt_cnt  = lt_r;
  assign res.eq_cnt  = eq_r;
  assign res.rng_cnt = rng_r;

endmodule

// ----- hdl/smse_checker.sv -----
module smse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input smse_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input smse_pkg::out_item_t out_item
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The block is not ready in the cycle after it accepts an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // There are never more distinct values than stored values.
  a_distinct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.distinct_count <= out_item.total_count)
    else $error("distinct count above total count");

  // An inverted range never reports matches.
  a_bad_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == smse_pkg::ST_BAD_RANGE |->
      out_item.match_count == '0)
    else $error("invalid range with nonzero match count");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_multiset_engine smse_checker u_smse_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smse_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned KEY_POOL_N   = 24;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_IDLE
  } idle_phase_t;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } op_mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sorted_multiset_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the store, kept in ascending order.
  logic signed [VAL_W-1:0] held_values [CAPACITY];
  int unsigned             held_count = 0;

  in_item_t    queued_ops[$];
  out_item_t   awaited_results[$];
  int unsigned accepted_items = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  idle_phase_t idle_phase;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  logic signed [VAL_W-1:0] key_pool [KEY_POOL_N];

  // Number of held values v with lo <= v <= hi.
  function automatic int unsigned count_span(input logic signed [VAL_W-1:0] lo,
                                             input logic signed [VAL_W-1:0] hi);
    int unsigned n;
    int unsigned i;
    n = 0;
    for (i = 0; i < held_count; i++) begin
      if (held_values[i] >= lo && held_values[i] <= hi) n++;
    end
    return n;
  endfunction

  // Applies one operation to the shadow store and returns the result it yields.
  function automatic out_item_t apply_operation(input in_item_t op_item);
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    int unsigned             pos;
    int unsigned             i;
    int unsigned             n_match;
    int unsigned             n_distinct;
    out_item_t               res;
    lo      = op_item.key;
    hi      = op_item.key_high;
    res     = '0;
    n_match = 0;
    case (op_item.op)
      OP_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_values[pos] < lo) pos++;
          for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
          held_values[pos] = lo;
          held_count++;
          res.status = ST_OK;
        end
      end
      OP_DELETE: begin
        pos = 0;
        while (pos < held_count && held_values[pos] != lo) pos++;
        if (pos >= held_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
          res.status = ST_OK;
        end
      end
      OP_COUNT: begin
        n_match    = count_span(lo, lo);
        res.status = ST_OK;
      end
      default: begin
        if (lo > hi) begin
          res.status = ST_BAD_RANGE;
        end else begin
          n_match    = count_span(lo, hi);
          res.status = ST_OK;
        end
      end
    endcase
    n_distinct = 0;
    for (i = 0; i < held_count; i++) begin
      if (i == 0 || held_values[i] != held_values[i-1]) n_distinct++;
    end
    res.match_count    = OUT_CNT_W'(n_match);
    res.total_count    = OUT_CNT_W'(held_count);
    res.distinct_count = OUT_CNT_W'(n_distinct);
    return res;
  endfunction

  task automatic add_op(input logic [1:0] op, input logic signed [VAL_W-1:0] k,
                        input logic signed [VAL_W-1:0] k_high);
    in_item_t it;
    it.op       = op;
    it.key      = k;
    it.key_high = k_high;
    queued_ops.push_back(it);
  endtask

  // Mostly keys from a small pool so that duplicates and delete hits are common.
  function automatic logic signed [VAL_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  // Idle pattern rotates through the phases as items are accepted.
  assign idle_phase = idle_phase_t'(2'(accepted_items / PHASE_ITEMS));

  always_comb begin
    case (idle_phase)
      PH_STEADY: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PH_SEND_GAPS: begin
        send_idle_pct  = 83;
        recv_stall_pct = 0;
      end
      PH_RECV_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 83;
      end
      default: begin
        send_idle_pct  = 11;
        recv_stall_pct = 11;
      end
    endcase
  end

  // Driver: predicts each accepted item, then presents the next one or idles.
  always @(posedge clk) begin : drive_proc
    logic holding;
    if (rst_n) begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_operation(in_item));
        accepted_items <= accepted_items + 1;
        holding = 1'b0;
      end
      if (!holding) begin
        if (queued_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= queued_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("Unexpected result %0d: status %0d match %0d total %0d distinct %0d",
                     results_seen, out_item.status, out_item.match_count,
                     out_item.total_count, out_item.distinct_count);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status ||
              out_item.match_count !== want.match_count ||
              out_item.total_count !== want.total_count ||
              out_item.distinct_count !== want.distinct_count) begin
            if (mismatches < REPORT_MAX)
              $display("Mismatch on result %0d: expected status %0d match %0d ",
                       results_seen, want.status, want.match_count,
                       "total %0d distinct %0d, got status %0d match %0d ",
                       want.total_count, want.distinct_count, out_item.status,
                       out_item.match_count, "total %0d distinct %0d",
                       out_item.total_count, out_item.distinct_count);
            mismatches++;
          end
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned             made;
    int unsigned             burst_len;
    int unsigned             burst_idx;
    int unsigned             i;
    int unsigned             r;
    op_mix_t                 mix;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] tmp;

    // Key pool: the extremes, values around zero, random values and neighbors.
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (i = 5; i < KEY_POOL_N; i++) begin
      if (i % 2 == 0) key_pool[i] = key_pool[i-1] + 1;
      else key_pool[i] = $urandom;
    end

    // Directed part: empty store, extremes, duplicates, not-found deletes and inverted ranges.
    add_op(OP_COUNT,  0, 0);
    add_op(OP_RANGE,  KEY_MIN, KEY_MAX);
    add_op(OP_DELETE, 5, 0);
    add_op(OP_INSERT, KEY_MIN, KEY_MAX);
    add_op(OP_INSERT, KEY_MAX, KEY_MIN);
    add_op(OP_INSERT, 0, 32'sh5555_5555);
    add_op(OP_INSERT, 0, 32'shAAAA_AAAA);
    add_op(OP_INSERT, -1, 0);
    add_op(OP_INSERT, 32'sh5555_5555, -1);
    add_op(OP_INSERT, 32'shAAAA_AAAA, 1);
    add_op(OP_COUNT,  0, KEY_MAX);
    add_op(OP_COUNT,  KEY_MIN, 0);
    add_op(OP_RANGE,  KEY_MIN, KEY_MAX);
    add_op(OP_RANGE,  0, 0);
    add_op(OP_RANGE,  -1, -1);
    // Inverted ranges, one by a single step and one across the whole span.
    add_op(OP_RANGE,  1, 0);
    add_op(OP_RANGE,  KEY_MAX, KEY_MIN);
    // Delete of a value that is not held.
    add_op(OP_DELETE, 7, 0);
    add_op(OP_DELETE, 0, 0);
    add_op(OP_COUNT,  0, 0);
    add_op(OP_DELETE, KEY_MAX, 0);
    add_op(OP_DELETE, KEY_MIN, 0);
    add_op(OP_RANGE,  KEY_MIN, -1);

    // Random part: bursts that fill the store toward capacity, mix, or drain it.
    made      = 0;
    burst_idx = 0;
    while (made < RANDOM_ITEMS) begin
      mix       = op_mix_t'(burst_idx % 3);
      burst_len = $urandom_range(80, 140);
      burst_idx++;
      for (i = 0; i < burst_len && made < RANDOM_ITEMS; i++) begin
        r = $urandom_range(99);
        case (mix)
          MIX_FILL:     r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 90) ? 2 : 3;
          MIX_DRAIN:    r = (r < 15) ? 0 : (r < 75) ? 1 : (r < 88) ? 2 : 3;
          default:      r = (r < 35) ? 0 : (r < 65) ? 1 : (r < 82) ? 2 : 3;
        endcase
        lo = pick_key();
        case (r)
          0: add_op(OP_INSERT, lo, $urandom);
          1: add_op(OP_DELETE, lo, $urandom);
          2: add_op(OP_COUNT,  lo, $urandom);
          default: begin
            r = $urandom_range(99);
            if (r < 70) begin
              hi = pick_key();
              if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
              end
            end else if (r < 85) begin
              hi = lo;
            end else begin
              hi = pick_key();
            end
            add_op(OP_RANGE, lo, hi);
          end
        endcase
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/smse_pkg.sv
hdl/smse_store.sv
hdl/smse_scan.sv
hdl/sorted_multiset_engine.sv
hdl/smse_checker.sv
sim/testbench.sv
